// ===== rtl/mbe_pkg.sv =====
// mbe_pkg: shared types and constants for the mandelbrot escape-time block
// no dependencies
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int OpW   = 32;
  localparam int ProdW = 2 * OpW;
  localparam int SumW  = 48;
  localparam int CntOutW = 16;
  localparam int CoordW  = 12;
  localparam int CfgAddrW = 3;

  localparam int DefFracBits  = 28;
  localparam int DefCoordBits = 12;
  localparam int DefIterBits  = 16;

  localparam logic signed [31:0] RstReOrigin = -32'sd536870912;
  localparam logic [30:0]        RstReStep   = 31'd1007894;
  localparam logic signed [31:0] RstImTop    = 32'sd402653184;
  localparam logic [30:0]        RstImStep   = 31'd1344418;
  localparam logic [15:0]        RstIterLim  = 16'd500;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_RE_ORIGIN  = 3'd0,
    CFG_RE_STEP    = 3'd1,
    CFG_IM_TOP     = 3'd2,
    CFG_IM_STEP    = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_addr_e;

  typedef struct packed {
    logic signed [31:0] re_origin;
    logic [30:0]        re_step;
    logic signed [31:0] im_top;
    logic [30:0]        im_step;
    logic [15:0]        iter_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RE,
    ST_C_IM,
    ST_C_FIN,
    ST_CHK,
    ST_RR,
    ST_II,
    ST_RI,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/mbe_mul.sv =====
// mbe_mul: shared signed multiplier with registered product
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_mul (
  input  logic                            clk_i,
  input  logic signed [mbe_pkg::OpW-1:0]  a_i,
  input  logic signed [mbe_pkg::OpW-1:0]  b_i,
  output logic signed [mbe_pkg::ProdW-1:0] p_o
);
  import mbe_pkg::*;

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/mbe_cfg.sv =====
// mbe_cfg: configuration register file with write-only port
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [mbe_pkg::CfgAddrW-1:0]       addr_i,
  input  logic [31:0]                        data_i,
  output mbe_pkg::cfg_t                      cfg_o
);
  import mbe_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_addr_e'(addr_i))
        CFG_RE_ORIGIN:  cfg_d.re_origin  = $signed(data_i);
        CFG_RE_STEP:    cfg_d.re_step    = data_i[30:0];
        CFG_IM_TOP:     cfg_d.im_top     = $signed(data_i);
        CFG_IM_STEP:    cfg_d.im_step    = data_i[30:0];
        CFG_ITER_LIMIT: cfg_d.iter_limit = data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.re_origin  <= RstReOrigin;
      cfg_q.re_step    <= RstReStep;
      cfg_q.im_top     <= RstImTop;
      cfg_q.im_step    <= RstImStep;
      cfg_q.iter_limit <= RstIterLim;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/mandelbrot_escape_iteration.sv =====
// a request passes ST_C_RE, ST_C_IM and ST_C_FIN, then the iterations, then ST_DONE;
// the escape test sits in ST_RI, after all three products; one multiplier is shared by the three
// products of each step, so every iteration passes through ST_CHK, ST_RR, ST_II and ST_RI
// one pixel at a time, taken only in ST_IDLE;
// a new request is taken while a result waits
// reset: async active low, clears control and sum, config to default view
`timescale 1ns / 1ps

module mandelbrot_escape_iteration #(
  parameter int FRAC_BITS  = mbe_pkg::DefFracBits,
  parameter int COORD_BITS = mbe_pkg::DefCoordBits,
  parameter int ITER_BITS  = mbe_pkg::DefIterBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // pixel_col, pixel_row
  input  logic                              s_axis_tuser,  // restart
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [63:0]                       m_axis_tdata,  // iter_count, checksum
  output logic                              m_axis_tuser   // escaped
);
  import mbe_pkg::*;

  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [ITER_BITS+15:0] LimMaxW =
    (ITER_BITS+16)'((64'd1 << ITER_BITS) - 64'd1);
  localparam logic [ProdW-1:0] Bound = ProdW'(64'd4 << (2 * FRAC_BITS));

  cfg_t cfg;

  mbe_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .addr_i (cfg_addr_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  state_e state_q, state_d;

  logic [CoordW-1:0]       x_q, y_q;
  logic                    restart_q;
  logic [ITER_BITS-1:0]    limit_q, limit_d;
  logic [ITER_BITS-1:0]    cnt_q;
  logic signed [31:0]      cre_q, cim_q, zr_q, zi_q;
  logic signed [ProdW-1:0] rr_q, ii_q;
  logic                    esc_q;

  logic                    out_valid_q;
  logic [CntOutW-1:0]      out_cnt_q;
  logic                    out_esc_q;
  logic [SumW-1:0]         sum_q;

  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  logic                    accept;
  logic                    out_load;
  logic                    escape_hit;
  logic signed [ProdW-1:0] re_next, im_next, c_re_w, c_im_w;
  logic [SumW-1:0]         sum_base;
  logic [SumW:0]           sum_add;

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > ProdW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -ProdW'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if ({{ITER_BITS{1'b0}}, cfg.iter_limit} > LimMaxW) begin
      limit_d = LimMaxW[ITER_BITS-1:0];
    end else begin
      limit_d = ITER_BITS'(cfg.iter_limit);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_C_RE;
      ST_C_RE:  state_d = ST_C_IM;
      ST_C_IM:  state_d = ST_C_FIN;
      ST_C_FIN: state_d = ST_CHK;
      ST_CHK:   state_d = (cnt_q < limit_q) ? ST_RR : ST_DONE;
      ST_RR:    state_d = ST_II;
      ST_II:    state_d = ST_RI;
      ST_RI:    state_d = escape_hit ? ST_DONE : ST_CHK;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = zr_q;
    mul_b = zr_q;
    case (state_q)
      ST_C_RE: begin
        mul_a = $signed({{(OpW-CoordW){1'b0}}, x_q});
        mul_b = $signed({1'b0, cfg.re_step});
      end
      ST_C_IM: begin
        mul_a = $signed({{(OpW-CoordW){1'b0}}, y_q});
        mul_b = $signed({1'b0, cfg.im_step});
      end
      ST_CHK: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      ST_RR: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      ST_II: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
    endcase
  end

  assign c_re_w     = ProdW'(cfg.re_origin) + prod;
  assign c_im_w     = ProdW'(cfg.im_top) - prod;
  assign escape_hit = ($unsigned(rr_q) + $unsigned(ii_q)) > Bound;
  assign re_next    = ((rr_q - ii_q) >>> FRAC_BITS) + ProdW'(cre_q);
  assign im_next    = (prod >>> (FRAC_BITS - 1)) + ProdW'(cim_q);
  assign sum_base   = restart_q ? '0 : sum_q;
  assign sum_add    = {1'b0, sum_base} + (SumW+1)'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      limit_q     <= '0;
      zr_q        <= '0;
      zi_q        <= '0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q   <= '0;
        limit_q <= limit_d;
        zr_q    <= '0;
        zi_q    <= '0;
        esc_q   <= 1'b0;
      end
      if (state_q == ST_RI) begin
        if (escape_hit) begin
          esc_q <= 1'b1;
        end else begin
          zr_q  <= sat32(re_next);
          zi_q  <= sat32(im_next);
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        sum_q       <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q       <= s_axis_tdata[11:0] & CoordMask;
      y_q       <= s_axis_tdata[23:12] & CoordMask;
      restart_q <= s_axis_tuser;
    end
    if (state_q == ST_C_IM) begin
      cre_q <= sat32(c_re_w);
    end
    if (state_q == ST_C_FIN) begin
      cim_q <= sat32(c_im_w);
    end
    if (state_q == ST_RR) begin
      rr_q <= prod;
    end
    if (state_q == ST_II) begin
      ii_q <= prod;
    end
    if (out_load) begin
      out_cnt_q <= CntOutW'(cnt_q);
      out_esc_q <= esc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {sum_q, out_cnt_q};
  assign m_axis_tuser  = out_esc_q;

`ifndef SYNTH
  a_cnt_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q <= limit_q))
    else $error("iteration count passed the limit");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done step");

  a_ri_after_ii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RI) |-> ($past(state_q) == ST_II))
    else $error("update step without the cross product");

  a_escape_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && esc_q) |-> (cnt_q < limit_q))
    else $error("escape flagged at the limit");
`endif

endmodule

// ===== dv/tb_mandelbrot_escape_iteration.sv =====
// tb_mandelbrot_escape_iteration: self-checking bench for the escape-time block
// predicts count, escaped flag and running sum per pixel; drives stream and config ports
// depends on rtl/mbe_pkg.sv and rtl/mandelbrot_escape_iteration.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_iteration;
  import mbe_pkg::*;

  localparam int FracBits = DefFracBits;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam longint unsigned EscapeBound = 64'd4 << (2 * FracBits);
  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;
  localparam int HoldCycles = 3000;

  typedef struct {
    logic [15:0] iters;
    logic        escaped;
    logic [47:0] total;
  } pixel_result_t;

  typedef struct {
    logic [CfgAddrW-1:0] addr;
    logic [31:0]         data;
  } reg_write_t;

  class escape_tracker;
    pixel_result_t      pending_pixels[$];
    logic signed [31:0] re_origin;
    logic [30:0]        re_step;
    logic signed [31:0] im_top;
    logic [30:0]        im_step;
    logic [15:0]        iter_limit;
    logic [47:0]        count_total;
    int n_pixels, n_escaped, n_capped, n_bad;

    function new();
      re_origin   = RstReOrigin;
      re_step     = RstReStep;
      im_top      = RstImTop;
      im_step     = RstImStep;
      iter_limit  = RstIterLim;
      count_total = '0;
      n_pixels    = 0;
      n_escaped   = 0;
      n_capped    = 0;
      n_bad       = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > S32Max) return S32Max;
      if (v < S32Min) return S32Min;
      return v;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] addr, logic [31:0] data);
      case (addr)
        CFG_RE_ORIGIN:  re_origin = data;
        CFG_RE_STEP:    re_step = data[30:0];
        CFG_IM_TOP:     im_top = data;
        CFG_IM_STEP:    im_step = data[30:0];
        CFG_ITER_LIMIT: iter_limit = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row, logic restart);
      longint c_re, c_im, zr, zi, rr, ii, ri;
      longint unsigned mag;
      int unsigned steps;
      bit esc;
      pixel_result_t r;
      c_re = clamp32(longint'(re_origin) + longint'(col) * longint'(re_step));
      c_im = clamp32(longint'(im_top) - longint'(row) * longint'(im_step));
      zr = 0;
      zi = 0;
      steps = 0;
      esc = 1'b0;
      while (steps < iter_limit) begin
        rr = zr * zr;
        ii = zi * zi;
        ri = zr * zi;
        mag = $unsigned(rr) + $unsigned(ii);
        if (mag > EscapeBound) begin
          esc = 1'b1;
          break;
        end
        zr = clamp32(((rr - ii) >>> FracBits) + c_re);
        zi = clamp32((ri >>> (FracBits - 1)) + c_im);
        steps++;
      end
      if (restart) count_total = '0;
      if (SumMax - count_total < steps) count_total = SumMax;
      else count_total = count_total + steps;
      r.iters   = steps[15:0];
      r.escaped = esc;
      r.total   = count_total;
      pending_pixels.push_back(r);
      n_pixels++;
      if (esc) n_escaped++;
      else n_capped++;
    endfunction

    function void check_pixel(logic [15:0] iters, logic escaped, logic [47:0] total);
      pixel_result_t want;
      if (pending_pixels.size() == 0) begin
        n_bad++;
        $display("%0t: result with no request pending, iter_count %0d", $time, iters);
        return;
      end
      want = pending_pixels.pop_front();
      if (iters !== want.iters) begin
        n_bad++;
        $display("%0t: iter_count expected %0d actual %0d", $time, want.iters, iters);
      end
      if (escaped !== want.escaped) begin
        n_bad++;
        $display("%0t: escaped expected %0b actual %0b", $time, want.escaped, escaped);
      end
      if (total !== want.total) begin
        n_bad++;
        $display("%0t: checksum expected %0d actual %0d", $time, want.total, total);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [31:0]         cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;  // pixel_col, pixel_row
  logic                s_axis_tuser;  // restart
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [63:0]         m_axis_tdata;  // iter_count, checksum
  logic                m_axis_tuser;  // escaped

  escape_tracker tracker = new();
  int  src_idle_pct;
  int  sink_idle_pct;
  bit  hold_pending;
  int  views;

  mandelbrot_escape_iteration dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic offer_pixel(input logic [11:0] col, input logic [11:0] row,
                             input logic restart);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_pixel(col, row, restart);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input reg_write_t wr[$]);
    foreach (wr[k]) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= wr[k].addr;
      cfg_data_i <= wr[k].data;
      @(posedge clk_i);
      tracker.set_reg(wr[k].addr, wr[k].data);
    end
    cfg_we_i <= 1'b0;
    views++;
  endtask

  task automatic set_view(input logic [31:0] re0, input logic [31:0] re_d,
                          input logic [31:0] im0, input logic [31:0] im_d,
                          input logic [15:0] lim);
    reg_write_t wr[$];
    wr.push_back(reg_write_t'{CFG_RE_ORIGIN, re0});
    wr.push_back(reg_write_t'{CFG_RE_STEP, re_d});
    wr.push_back(reg_write_t'{CFG_IM_TOP, im0});
    wr.push_back(reg_write_t'{CFG_IM_STEP, im_d});
    wr.push_back(reg_write_t'{CFG_ITER_LIMIT, {16'd0, lim}});
    write_regs(wr);
  endtask

  task automatic random_phase(input int n, input bit wild, input logic [15:0] lim,
                              input bit squeeze);
    logic [31:0] re0, re_d, im0, im_d;
    if (wild) begin
      re0  = $urandom;
      re_d = $urandom;
      im0  = $urandom;
      im_d = $urandom;
    end else begin
      // window around the set: real -2.5..0.5, imaginary top -1.5..1.5
      re0  = $urandom_range(0, 805306368) - 32'd671088640;
      re_d = $urandom_range(0, 400000) | ($urandom_range(0, 1) << 31);
      im0  = $urandom_range(0, 805306368) - 32'd402653184;
      im_d = $urandom_range(0, 400000) | ($urandom_range(0, 1) << 31);
    end
    set_view(re0, re_d, im0, im_d, lim);
    if (squeeze) hold_pending = 1'b1;
    repeat (n) offer_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           $urandom_range(0, 19) == 0);
    drain();
  endtask

  // result side: checks every accepted result, stalls at random or for a long hold
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        tracker.check_pixel(m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[63:16]);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int unsigned lims[8];
    bit wilds[8];
    reg_write_t junk[$];
    lims  = '{1, 8, 500, 33, 64, 255, 20, 100};
    wilds = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    hold_pending  = 1'b0;
    views         = 1;
    src_idle_pct  = 32;
    sink_idle_pct = 83;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default window, limit 500: far corners, points deep inside, restarts
    offer_pixel(12'd0, 12'd0, 1'b1);
    offer_pixel(12'd4095, 12'd4095, 1'b0);
    offer_pixel(12'd0, 12'd4095, 1'b0);
    offer_pixel(12'd4095, 12'd0, 1'b0);
    offer_pixel(12'd533, 12'd300, 1'b0);
    offer_pixel(12'd400, 12'd300, 1'b0);
    offer_pixel(12'd266, 12'd300, 1'b1);
    offer_pixel(12'd600, 12'd100, 1'b0);
    drain();

    // writes to unused indexes must leave the view alone
    for (int a = int'(CFG_ITER_LIMIT) + 1; a < (1 << CfgAddrW); a++)
      junk.push_back(reg_write_t'{a[CfgAddrW-1:0], $urandom});
    write_regs(junk);
    offer_pixel(12'd100, 12'd50, 1'b0);
    offer_pixel(12'd533, 12'd301, 1'b1);
    drain();

    // zero limit
    junk.delete();
    junk.push_back(reg_write_t'{CFG_ITER_LIMIT, 32'd0});
    write_regs(junk);
    offer_pixel(12'd533, 12'd300, 1'b0);
    offer_pixel(12'd0, 12'd0, 1'b1);
    offer_pixel(12'd4095, 12'd4095, 1'b0);
    drain();

    // extreme registers: point coordinates saturate
    set_view(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    offer_pixel(12'd0, 12'd0, 1'b0);
    offer_pixel(12'd4095, 12'd4095, 1'b0);
    offer_pixel(12'd4095, 12'd0, 1'b0);
    offer_pixel(12'd0, 12'd4095, 1'b1);
    drain();
    set_view(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 16'hFFFF);
    offer_pixel(12'd7, 12'd7, 1'b0);
    drain();

    // origin point runs to the widest limit
    set_view(32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF);
    offer_pixel(12'd1234, 12'd2345, 1'b0);
    drain();

    // c = -2 sits exactly on the bound and never escapes
    set_view(32'hE000_0000, 32'd0, 32'd0, 32'd0, 16'd300);
    offer_pixel(12'd4095, 12'd4095, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        src_idle_pct  = 83;
        sink_idle_pct = 32;
      end
      if (p == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      random_phase(150, wilds[p], 16'(lims[p]), p == 6);
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("covered %0d pixels over %0d register views: %0d escaped, %0d ran to the limit",
             tracker.n_pixels, views, tracker.n_escaped, tracker.n_capped);
    $display("limits from 0 to 65535, saturated coordinates, long output stall included");
    if (tracker.n_bad == 0 && tracker.pending_pixels.size() == 0) begin
      $display("tb_mandelbrot_escape_iteration: clean");
    end else begin
      $display("tb_mandelbrot_escape_iteration: errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_mandelbrot_escape_iteration: errors");
    $finish;
  end

endmodule
